>>> design/max_square_window_sum_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the maximum square window sum block
// Shared concurrent assertion forms; each use expects clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef MAX_SQUARE_WINDOW_SUM_MACROS_SVH
`define MAX_SQUARE_WINDOW_SUM_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define MSWS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define MSWS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/msws_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Maximum square window sum package
// Sizes, register codes, pipeline structs and the side clamp helper.
// ----------------------------------------------------------------------------
package msws_pkg;

  // Largest supported matrix side and element width.
  localparam int MAX_SIDE   = 128;
  localparam int VALUE_BITS = 16;

  // Port widths fixed by the interface.
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 32;
  localparam int OUT_W       = 30;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int REG_W       = 8;

  // Derived internal widths.
  localparam int DATA_W = (VALUE_BITS < IN_TDATA_W) ? VALUE_BITS : IN_TDATA_W;
  localparam int SIDE_W = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam int CNT_W  = $clog2(MAX_SIDE + 1);
  localparam int ADDR_W = 2 * SIDE_W;
  localparam int COL_W  = DATA_W + SIDE_W;
  localparam int SUM_W  = DATA_W + 2 * SIDE_W;

  // Register indexes (address bit 2) and reset values.
  localparam logic REG_MATRIX_SIZE = 1'b0;
  localparam logic REG_WINDOW_SIZE = 1'b1;
  localparam logic [REG_W-1:0] MATRIX_SIZE_RST = REG_W'(8);
  localparam logic [REG_W-1:0] WINDOW_SIZE_RST = REG_W'(2);

  // One element as it leaves the accept stage.
  typedef struct packed {
    logic              vld;
    logic              act;       // window fits the matrix
    logic              sub_rs;    // row at or below p: drop the element p rows up
    logic              win_row;   // a full window height is present
    logic              col0;      // first column restarts the running sum
    logic              sub_csp;   // drop the column sum p columns back
    logic              cand_col;  // a full window width is present
    logic              last;      // last element of the matrix
    logic [SIDE_W-1:0] col;
    logic [SIDE_W-1:0] colp;
    logic [DATA_W-1:0] v;
  } req_t;

  // Updated column sum handed to the window stage.
  typedef struct packed {
    logic             vld;
    logic             act;
    logic             win_row;
    logic             col0;
    logic             sub_csp;
    logic             cand_col;
    logic             last;
    logic [COL_W-1:0] cs_new;
    logic [COL_W-1:0] csp;
  } cs_t;

  // Zero is taken as one and sizes above the maximum saturate.
  function automatic logic [CNT_W-1:0] side_clamp(input logic [REG_W-1:0] s);
    logic [CNT_W-1:0] res;
    if (s == '0) begin
      res = CNT_W'(1);
    end else if (int'(s) > MAX_SIDE) begin
      res = CNT_W'(MAX_SIDE);
    end else begin
      res = CNT_W'(s);
    end
    return res;
  endfunction

endpackage

>>> design/msws_line_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line store
// Holds the elements of the current matrix by row and column, one write and
// one registered read per cycle.
// ----------------------------------------------------------------------------
module msws_line_store (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [msws_pkg::ADDR_W-1:0]  wr_addr,
  input  logic [msws_pkg::DATA_W-1:0]  wr_data,
  input  logic [msws_pkg::ADDR_W-1:0]  rd_addr,
  output logic [msws_pkg::DATA_W-1:0]  rd_data
);
  import msws_pkg::*;

  localparam int DEPTH = 1 << ADDR_W;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  // Element write and read of the element p rows up.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

>>> design/msws_col_store.sv
`timescale 1ns / 1ps
`include "max_square_window_sum_macros.svh"
// ----------------------------------------------------------------------------
// Column sum store
// Keeps one sum per column over the last p rows. Reads two columns, updates
// one and writes it back, forwarding the value that is still being written.
// ----------------------------------------------------------------------------
module msws_col_store (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         clear,
  input  msws_pkg::req_t               s0,
  input  logic [msws_pkg::DATA_W-1:0]  rs_rdata,
  output logic                         s1_last,
  output msws_pkg::cs_t                s2
);
  import msws_pkg::*;

  // Source of a column sum read.
  localparam logic [1:0] SEL_ZERO = 2'd0;
  localparam logic [1:0] SEL_MEM  = 2'd1;
  localparam logic [1:0] SEL_FWD  = 2'd2;

  logic [COL_W-1:0]    mem [MAX_SIDE];
  logic [MAX_SIDE-1:0] valid_r, valid_nxt;
  req_t                s1_r;
  cs_t                 s2_r;
  logic [COL_W-1:0]    rd_a_r, rd_b_r, fwd_r;
  logic [1:0]          sel_a_nxt, sel_b_nxt, sel_a_r, sel_b_r;
  logic [COL_W-1:0]    cs_old, csp, rs, cs_new;
  logic                s1_wr;

  assign s1_wr = s1_r.vld && s1_r.act;

  // Pick the source for each read: a matrix restart reads zero, the entry
  // written this cycle is forwarded, and an entry not yet written reads zero.
  always_comb begin
    if (s1_r.vld && s1_r.last) begin
      sel_a_nxt = SEL_ZERO;
    end else if (s1_wr && (s1_r.col == s0.col)) begin
      sel_a_nxt = SEL_FWD;
    end else if (!valid_r[s0.col]) begin
      sel_a_nxt = SEL_ZERO;
    end else begin
      sel_a_nxt = SEL_MEM;
    end
    if (s1_r.vld && s1_r.last) begin
      sel_b_nxt = SEL_ZERO;
    end else if (s1_wr && (s1_r.col == s0.colp)) begin
      sel_b_nxt = SEL_FWD;
    end else if (!valid_r[s0.colp]) begin
      sel_b_nxt = SEL_ZERO;
    end else begin
      sel_b_nxt = SEL_MEM;
    end
  end

  // Valid bits clear on a new matrix and set on each write.
  always_comb begin
    valid_nxt = valid_r;
    if (clear || (s1_r.vld && s1_r.last)) begin
      valid_nxt = '0;
    end else if (s1_wr) begin
      valid_nxt[s1_r.col] = 1'b1;
    end
  end

  // Memory access: write back the updated sum, read two columns.
  always_ff @(posedge clk) begin
    if (s1_wr) begin
      mem[s1_r.col] <= cs_new;
    end
    rd_a_r <= mem[s0.col];
    rd_b_r <= mem[s0.colp];
    fwd_r  <= cs_new;
  end

  // Resolve the read data.
  always_comb begin
    case (sel_a_r)
      SEL_MEM: cs_old = rd_a_r;
      SEL_FWD: cs_old = fwd_r;
      default: cs_old = '0;
    endcase
    case (sel_b_r)
      SEL_MEM: csp = rd_b_r;
      SEL_FWD: csp = fwd_r;
      default: csp = '0;
    endcase
  end

  // Column sum update: drop the element p rows up, add the new one.
  assign rs     = s1_r.sub_rs ? COL_W'(rs_rdata) : '0;
  assign cs_new = COL_W'(cs_old - rs + COL_W'(s1_r.v));

  // Stage registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      s1_r    <= '0;
      s2_r    <= '0;
      sel_a_r <= SEL_ZERO;
      sel_b_r <= SEL_ZERO;
    end else begin
      valid_r       <= valid_nxt;
      s1_r          <= s0;
      sel_a_r       <= sel_a_nxt;
      sel_b_r       <= sel_b_nxt;
      s2_r.vld      <= s1_r.vld;
      s2_r.act      <= s1_r.act;
      s2_r.win_row  <= s1_r.win_row;
      s2_r.col0     <= s1_r.col0;
      s2_r.sub_csp  <= s1_r.sub_csp;
      s2_r.cand_col <= s1_r.cand_col;
      s2_r.last     <= s1_r.last;
      s2_r.cs_new   <= cs_new;
      s2_r.csp      <= csp;
    end
  end

  assign s1_last = s1_r.vld && s1_r.last;
  assign s2      = s2_r;

  // Checks on the read-modify-write path.
  `MSWS_ASSERT_NEXT(a_restart_clears, s1_r.vld && s1_r.last, valid_r == '0, "valid bits survived a matrix restart")
  `MSWS_ASSERT_NEXT(a_write_marks, s1_wr && !s1_r.last && !clear, valid_r[$past(s1_r.col)], "written column not marked valid")
  `MSWS_ASSERT_SAME(a_fwd_source, sel_a_r == SEL_FWD || sel_b_r == SEL_FWD, $past(s1_wr), "forwarding without a preceding write")

endmodule

>>> design/msws_window.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Window sum and maximum
// Runs the sum of the last p column sums along a row, tracks the largest
// full window and holds the result until it is taken.
// ----------------------------------------------------------------------------
module msws_window (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        clear,
  input  msws_pkg::cs_t               s2,
  input  logic                        out_tready,
  output logic                        out_tvalid,
  output logic [msws_pkg::OUT_W-1:0]  out_data,
  output logic                        busy_last
);
  import msws_pkg::*;

  logic [SUM_W-1:0] ws_r, ws_base, ws_new, best_r, best_nxt;
  logic             s3_vld_r, s3_cand_r, s3_last_r;
  logic             out_valid_r;
  logic [OUT_W-1:0] out_data_r;
  logic             upd;

  // Running window sum: restart at the row start, add the new column,
  // drop the column that left the window.
  assign upd     = s2.vld && s2.act && s2.win_row;
  assign ws_base = s2.col0 ? '0 : ws_r;
  assign ws_new  = SUM_W'(ws_base + SUM_W'(s2.cs_new)
                   - (s2.sub_csp ? SUM_W'(s2.csp) : SUM_W'(0)));

  // Maximum over full windows, one item behind the running sum.
  assign best_nxt = (s3_vld_r && s3_cand_r && (ws_r > best_r)) ? ws_r : best_r;

  // Control and accumulator registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ws_r        <= '0;
      best_r      <= '0;
      s3_vld_r    <= 1'b0;
      s3_cand_r   <= 1'b0;
      s3_last_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s3_vld_r  <= s2.vld;
      s3_cand_r <= upd && s2.cand_col;
      s3_last_r <= s2.last;
      if (clear) begin
        ws_r   <= '0;
        best_r <= '0;
      end else begin
        if (upd) begin
          ws_r <= ws_new;
        end
        if (s3_vld_r && s3_last_r) begin
          best_r <= '0;
        end else begin
          best_r <= best_nxt;
        end
      end
      if (s3_vld_r && s3_last_r) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (s3_vld_r && s3_last_r) begin
      out_data_r <= OUT_W'(best_nxt);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_data   = out_data_r;
  assign busy_last  = (s2.vld && s2.last) || (s3_vld_r && s3_last_r);

endmodule

>>> design/max_square_window_sum.sv
`timescale 1ns / 1ps
`include "max_square_window_sum_macros.svh"
// ----------------------------------------------------------------------------
// Maximum square window sum
// Largest p-by-p window sum over an n-by-n matrix streamed in raster order.
//
//   Channel  Direction  Payload                     Transfer
//   in_*     input      value_in, tdata[15:0]       in_tvalid & in_tready
//   out_*    output     best_sum, tdata[29:0]       out_tvalid & out_tready
//   cfg_*    input      matrix_size @0, window @4   psel & penable & pwrite
//
// One element is taken per cycle while in_tready is high. After its last element
// is taken, the result of a matrix passes the s1, s2 and s3 stage registers on
// its way to the output register; the column sum memory read-modify-write with
// forwarding sets that rate. The last element of a matrix waits while an earlier
// result is still in flight, or is held in the output register while the result
// side stalls.
// Reset takes effect at once; the line store is not cleared and needs no
// clearing pass. A configuration write restarts the matrix.
// ----------------------------------------------------------------------------
module max_square_window_sum (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [msws_pkg::IN_TDATA_W-1:0]  in_tdata,    // [15:0] value_in
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [msws_pkg::OUT_TDATA_W-1:0] out_tdata,   // [29:0] best_sum
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [msws_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [msws_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [msws_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                             cfg_pready
);
  import msws_pkg::*;

  logic [REG_W-1:0]  matrix_size_r, window_size_r;
  logic [SIDE_W-1:0] row_r, row_nxt, col_r, col_nxt;
  logic [CNT_W-1:0]  n_eff, p_c, row_ext, col_ext;
  logic              cfg_wr, active, last_col, last_pos;
  logic              in_acc, out_block, s1_last, busy_last;
  req_t              s0;
  cs_t               s2;
  logic [DATA_W-1:0] rs_rdata;
  logic [OUT_W-1:0]  out_data;

  // Configuration port.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == REG_WINDOW_SIZE) ? CFG_DATA_W'(window_size_r)
                                                       : CFG_DATA_W'(matrix_size_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      matrix_size_r <= MATRIX_SIZE_RST;
      window_size_r <= WINDOW_SIZE_RST;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == REG_MATRIX_SIZE) begin
        matrix_size_r <= cfg_pwdata[REG_W-1:0];
      end else begin
        window_size_r <= cfg_pwdata[REG_W-1:0];
      end
    end
  end

  // Effective sizes and position flags.
  assign n_eff    = side_clamp(matrix_size_r);
  assign p_c      = CNT_W'(window_size_r);
  assign active   = (window_size_r != '0) && (int'(window_size_r) <= int'(n_eff));
  assign row_ext  = CNT_W'(row_r);
  assign col_ext  = CNT_W'(col_r);
  assign last_col = (col_ext + CNT_W'(1)) == n_eff;
  assign last_pos = last_col && ((row_ext + CNT_W'(1)) == n_eff);

  // Input flow: only the last element of a matrix needs a free result slot.
  assign in_acc    = in_tvalid && in_tready;
  assign out_block = out_tvalid && !out_tready;
  assign in_tready = !last_pos || (!s1_last && !busy_last && !out_block);

  // Accept stage request.
  always_comb begin
    s0.vld      = in_acc;
    s0.act      = active;
    s0.sub_rs   = row_ext >= p_c;
    s0.win_row  = (row_ext + CNT_W'(1)) >= p_c;
    s0.col0     = (col_r == '0);
    s0.sub_csp  = col_ext >= p_c;
    s0.cand_col = (col_ext + CNT_W'(1)) >= p_c;
    s0.last     = last_pos;
    s0.col      = col_r;
    s0.colp     = SIDE_W'(col_ext - p_c);
    s0.v        = DATA_W'(in_tdata);
  end

  // Raster position counters.
  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    if (cfg_wr) begin
      row_nxt = '0;
      col_nxt = '0;
    end else if (in_acc) begin
      if (last_pos) begin
        row_nxt = '0;
        col_nxt = '0;
      end else if (last_col) begin
        row_nxt = row_r + SIDE_W'(1);
        col_nxt = '0;
      end else begin
        col_nxt = col_r + SIDE_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
    end else begin
      row_r <= row_nxt;
      col_r <= col_nxt;
    end
  end

  // Element memory.
  msws_line_store u_line_store (
    .clk     (clk),
    .wr_en   (in_acc),
    .wr_addr ({row_r, col_r}),
    .wr_data (s0.v),
    .rd_addr ({SIDE_W'(row_ext - p_c), col_r}),
    .rd_data (rs_rdata)
  );

  // Column sums.
  msws_col_store u_col_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .clear    (cfg_wr),
    .s0       (s0),
    .rs_rdata (rs_rdata),
    .s1_last  (s1_last),
    .s2       (s2)
  );

  // Window sum, maximum and result register.
  msws_window u_window (
    .clk        (clk),
    .rst_n      (rst_n),
    .clear      (cfg_wr),
    .s2         (s2),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_data   (out_data),
    .busy_last  (busy_last)
  );

  assign out_tdata = OUT_TDATA_W'(out_data);

  // Checks on position tracking and result flow.
  `MSWS_ASSERT_SAME(a_pos_range, 1'b1, (row_ext < n_eff) && (col_ext < n_eff),
                    "position outside the matrix")
  `MSWS_ASSERT_NEXT(a_cfg_restart, cfg_wr, (row_r == '0) && (col_r == '0),
                    "configuration write did not restart the matrix")
  `MSWS_ASSERT_SAME(a_last_slot, in_acc && last_pos, !out_block && !busy_last && !s1_last,
                    "last element taken without a free result slot")

endmodule
